// File: hw/rtl/enc_ase_pkg.sv
`timescale 1ns / 1ps

package enc_ase_pkg;

  // Build-time sizes of the position counter and of the electrical phase.
  localparam int COUNT_BITS = 16;
  localparam int PHASE_BITS = 16;

  // Port widths fixed by the interface.
  localparam int COUNT_PORT_W = 16;
  localparam int ANGLE_PORT_W = 16;
  localparam int SPEED_W      = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 24;

  // Configuration register widths.
  localparam int SCALE_W   = 24;
  localparam int THRESH_W  = 15;
  localparam int TIMEOUT_W = 16;
  localparam int TICK_W    = 10;

  // Elapsed-time counter, saturating.
  localparam int ELAPSED_W = 20;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  // Microseconds in one second, used to scale the speed.
  localparam int US_PER_SECOND = 1000000;
  localparam int US_W          = 20;

  // Register reset values.
  localparam logic [SCALE_W-1:0]   SCALE_RESET   = 24'd1048576;
  localparam logic [THRESH_W-1:0]  THRESH_RESET  = 15'd5461;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd15000;
  localparam logic [TICK_W-1:0]    TICK_RESET    = 10'd100;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ELEC_SCALE      = 2'd0,
    REG_ANGLE_THRESHOLD = 2'd1,
    REG_TIMEOUT_US      = 2'd2,
    REG_TICK_US         = 2'd3
  } cfg_reg_t;

endpackage

// File: hw/rtl/encoder_angle_speed_estimator_top.sv
`timescale 1ns / 1ps

// Encoder angle and speed estimator.
// One input transfer per control tick carries the encoder position count and
// the direction flag; each one yields exactly one result transfer with the
// electrical angle, the held signed speed and a flag telling whether the
// speed was recomputed on this tick.
// Both channels use valid and stall. in_stall is high while an item is being
// worked on; the block takes the next item as soon as it is back in idle,
// even while the previous result still waits in the output register.
// The division runs as a restoring divider, one quotient bit per cycle over
// the 36-bit scaled distance; an update that needs no division (zero
// distance or zero elapsed time) skips it, as does a tick whose speed is
// held.
// If the receiver stalls, the finished result waits in the final state until
// the output register is free; nothing is dropped.
// Configuration writes through cfg_we, cfg_index and cfg_data take effect at
// once and should be made while the block is idle.
// Synchronous reset (rst_n low) loads the register defaults, clears the
// reference phase, timer, direction latch and held speed, and empties the
// output register.

module encoder_angle_speed_estimator_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [enc_ase_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [enc_ase_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [enc_ase_pkg::COUNT_PORT_W-1:0]  in_position_count,
  input  logic                                  in_direction_flag,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [enc_ase_pkg::ANGLE_PORT_W-1:0]  out_elec_angle,
  output logic signed [enc_ase_pkg::SPEED_W-1:0] out_speed,
  output logic                                  out_speed_updated
);

  import enc_ase_pkg::*;

  // Derived widths.
  localparam int CNT_W      = (COUNT_BITS < COUNT_PORT_W) ? COUNT_BITS : COUNT_PORT_W;
  localparam int PROD_W     = ((CNT_W + SCALE_W) > (16 + PHASE_BITS)) ?
                              (CNT_W + SCALE_W) : (16 + PHASE_BITS);
  localparam int ANG_EXT_W  = PHASE_BITS + ANGLE_PORT_W;
  localparam int DIVIDEND_W = PHASE_BITS + US_W;
  localparam int MAG_W      = (DIVIDEND_W > SPEED_W + 1) ? DIVIDEND_W : SPEED_W + 1;
  localparam int ITER_W     = $clog2(DIVIDEND_W + 1);
  localparam int CMP_W      = 32;

  localparam logic [PHASE_BITS-1:0] PHASE_HALF = {1'b1, {(PHASE_BITS-1){1'b0}}};
  localparam logic [MAG_W-1:0] POS_LIMIT = MAG_W'(64'h0000_0000_7FFF_FFFF);
  localparam logic [MAG_W-1:0] NEG_LIMIT = MAG_W'(64'h0000_0000_8000_0000);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PHASE = 7'b0000010,
    S_DIST  = 7'b0000100,
    S_DMUL  = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_SPEED = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [SCALE_W-1:0]   elec_scale_r;
  logic [THRESH_W-1:0]  thresh_r;
  logic [TIMEOUT_W-1:0] timeout_r;
  logic [TICK_W-1:0]    tick_r;

  // Estimator state.
  logic [PHASE_BITS-1:0] ref_angle_r;
  logic [ELAPSED_W-1:0]  elapsed_r;
  logic                  latched_dir_r;
  logic                  prev_nz_r;
  logic [SPEED_W-1:0]    held_speed_r;

  // Per-item working registers.
  logic [CNT_W-1:0]      cnt_r;
  logic [PHASE_BITS-1:0] angle_r;
  logic [PHASE_BITS-1:0] phase_dist_r;
  logic                  upd_r;
  logic                  sat_r;
  logic [ELAPSED_W-1:0]  div_r;
  logic [ELAPSED_W-1:0]  rem_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [ITER_W-1:0]     iter_r;

  // Output register.
  logic                    out_valid_r;
  logic [ANGLE_PORT_W-1:0] out_angle_r;
  logic [SPEED_W-1:0]      out_speed_r;
  logic                    out_upd_r;

  logic                  in_xfer;
  logic                  out_xfer;
  logic                  out_load;
  logic [CNT_W-1:0]      in_cnt;
  logic [PROD_W-1:0]     prod;
  logic [ELAPSED_W:0]    elapsed_sum;
  logic [PHASE_BITS-1:0] diff;
  logic [PHASE_BITS-1:0] phase_dist;
  logic                  need_update;
  logic [ELAPSED_W:0]    trial;
  logic [ELAPSED_W:0]    trial_diff;
  logic                  trial_ge;
  logic [MAG_W-1:0]      mag;
  logic [MAG_W-1:0]      mag_pos;
  logic [MAG_W-1:0]      mag_neg;
  logic [ANG_EXT_W-1:0]  angle_ext;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign out_load = (state_r == S_FIN) && (!out_valid_r || !out_stall);
  assign in_cnt   = in_position_count[CNT_W-1:0];
  assign in_stall = (state_r != S_IDLE);

  // Phase scaling and elapsed-time accumulation.
  assign prod        = PROD_W'(cnt_r) * PROD_W'(elec_scale_r);
  assign elapsed_sum = {1'b0, elapsed_r} + (ELAPSED_W + 1)'(tick_r);

  // Shortest wrapped distance to the reference phase and the update decision.
  assign diff = angle_r - ref_angle_r;
  assign phase_dist = (diff > PHASE_HALF) ? (PHASE_BITS'(0) - diff) : diff;
  assign need_update = (CMP_W'(phase_dist) > CMP_W'(thresh_r)) ||
                       (CMP_W'(elapsed_r) > CMP_W'(timeout_r));

  // One restoring divider step: shift in the next dividend bit, subtract if it fits.
  assign trial      = {rem_r, quo_r[DIVIDEND_W-1]};
  assign trial_diff = trial - {1'b0, div_r};
  assign trial_ge   = (trial >= {1'b0, div_r});

  // Saturation of the magnitude for each direction.
  assign mag     = sat_r ? '1 : MAG_W'(quo_r);
  assign mag_pos = (mag > POS_LIMIT) ? POS_LIMIT : mag;
  assign mag_neg = (mag > NEG_LIMIT) ? NEG_LIMIT : mag;

  assign angle_ext = ANG_EXT_W'(angle_r);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_PHASE;
        end
      end
      S_PHASE: state_nxt = S_DIST;
      S_DIST: begin
        if (!need_update) begin
          state_nxt = S_FIN;
        end else if (phase_dist == '0 || elapsed_r == '0) begin
          state_nxt = S_SPEED;
        end else begin
          state_nxt = S_DMUL;
        end
      end
      S_DMUL: state_nxt = S_DIV;
      S_DIV: begin
        if (iter_r == ITER_W'(1)) begin
          state_nxt = S_SPEED;
        end
      end
      S_SPEED: state_nxt = S_FIN;
      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elec_scale_r <= SCALE_RESET;
      thresh_r     <= THRESH_RESET;
      timeout_r    <= TIMEOUT_RESET;
      tick_r       <= TICK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ELEC_SCALE:      elec_scale_r <= cfg_data[SCALE_W-1:0];
        REG_ANGLE_THRESHOLD: thresh_r     <= cfg_data[THRESH_W-1:0];
        REG_TIMEOUT_US:      timeout_r    <= cfg_data[TIMEOUT_W-1:0];
        REG_TICK_US:         tick_r       <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Estimator state: direction latch, timer, reference phase and held speed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_angle_r   <= '0;
      elapsed_r     <= '0;
      latched_dir_r <= 1'b0;
      prev_nz_r     <= 1'b0;
      held_speed_r  <= '0;
    end else begin
      if (in_xfer) begin
        if (prev_nz_r) begin
          latched_dir_r <= in_direction_flag;
        end
        prev_nz_r <= (in_cnt != '0);
      end
      if (state_r == S_PHASE) begin
        elapsed_r <= elapsed_sum[ELAPSED_W] ? ELAPSED_MAX : elapsed_sum[ELAPSED_W-1:0];
      end
      if (state_r == S_DIST && need_update) begin
        ref_angle_r <= angle_r;
        elapsed_r   <= '0;
      end
      if (state_r == S_SPEED) begin
        held_speed_r <= latched_dir_r ? mag_pos[SPEED_W-1:0] :
                        (SPEED_W'(0) - mag_neg[SPEED_W-1:0]);
      end
    end
  end

  // Working registers of the current item; the divider reuses quo_r as its
  // dividend shift register.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cnt_r <= in_cnt;
    end
    case (state_r)
      S_PHASE: begin
        angle_r <= prod[16 +: PHASE_BITS];
      end
      S_DIST: begin
        phase_dist_r <= phase_dist;
        upd_r        <= need_update;
        div_r        <= elapsed_r;
        sat_r        <= (phase_dist != '0) && (elapsed_r == '0);
        quo_r        <= '0;
      end
      S_DMUL: begin
        quo_r  <= DIVIDEND_W'(phase_dist_r) * DIVIDEND_W'(US_PER_SECOND);
        rem_r  <= '0;
        iter_r <= ITER_W'(DIVIDEND_W);
      end
      S_DIV: begin
        rem_r  <= trial_ge ? trial_diff[ELAPSED_W-1:0] : trial[ELAPSED_W-1:0];
        quo_r  <= {quo_r[DIVIDEND_W-2:0], trial_ge};
        iter_r <= iter_r - ITER_W'(1);
      end
      default: ;
    endcase
  end

  // Output register: loaded from the final state when empty or being emptied.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_angle_r <= angle_ext[ANGLE_PORT_W-1:0];
      out_speed_r <= held_speed_r;
      out_upd_r   <= upd_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_elec_angle    = out_angle_r;
  assign out_speed         = out_speed_r;
  assign out_speed_updated = out_upd_r;

`ifndef SYNTHESIS
  // A new result appears only after the sequencer has finished an item.
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result became valid outside the final state");

  // The held speed changes only in the speed update step.
  a_speed_only_on_update: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(held_speed_r)) |-> $past(state_r == S_SPEED))
    else $error("held speed changed outside the update step");

  // The divider remainder always stays below a nonzero divisor.
  a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (div_r != '0 && rem_r < div_r))
    else $error("divider remainder out of range");
`endif

endmodule

// File: sim/tb_encoder_angle_speed_estimator_top.sv
`timescale 1ns / 1ps

module tb_encoder_angle_speed_estimator_top;

  import enc_ase_pkg::*;

  localparam int SETTLE_CYCLES = 64;

  // One encoder sample as offered on the input channel.
  typedef struct packed {
    logic [COUNT_PORT_W-1:0] count;
    logic                    dir;
  } encoder_sample_t;

  // One estimate as it should appear on the result channel.
  typedef struct packed {
    logic [ANGLE_PORT_W-1:0]  angle;
    logic signed [SPEED_W-1:0] speed;
    logic                     updated;
  } angle_speed_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [COUNT_PORT_W-1:0] in_position_count = '0;
  logic in_direction_flag = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ANGLE_PORT_W-1:0] out_elec_angle;
  logic signed [SPEED_W-1:0] out_speed;
  logic out_speed_updated;

  encoder_sample_t pending_samples[$];
  angle_speed_t expected_estimates[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;

  // Register copies used by the estimator below.
  logic [SCALE_W-1:0]   est_scale   = SCALE_RESET;
  logic [THRESH_W-1:0]  est_thresh  = THRESH_RESET;
  logic [TIMEOUT_W-1:0] est_timeout = TIMEOUT_RESET;
  logic [TICK_W-1:0]    est_tick    = TICK_RESET;

  // Tracker state of the estimator.
  logic [PHASE_BITS-1:0] est_ref_angle = '0;
  logic [ELAPSED_W-1:0]  est_elapsed = '0;
  logic                  est_dir = 1'b0;
  logic                  est_prev_nonzero = 1'b0;
  logic [SPEED_W-1:0]    est_speed = '0;

  // Position state of the random motion generator.
  logic [COUNT_PORT_W-1:0] walk_count = '0;

  encoder_angle_speed_estimator_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_position_count (in_position_count),
    .in_direction_flag (in_direction_flag),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_elec_angle    (out_elec_angle),
    .out_speed         (out_speed),
    .out_speed_updated (out_speed_updated)
  );

  always #5 clk = ~clk;

  // Advances the tracker by one tick and returns the estimate it yields.
  function automatic angle_speed_t estimate_tick(logic [COUNT_PORT_W-1:0] count,
                                                 logic dir_flag);
    angle_speed_t est;
    logic [39:0] product;
    logic [PHASE_BITS-1:0] angle;
    logic [PHASE_BITS-1:0] phase_dist;
    logic [ELAPSED_W:0] elapsed_sum;
    logic [63:0] mag;
    if (est_prev_nonzero) begin
      est_dir = dir_flag;
    end
    est_prev_nonzero = (count != '0);

    product = 40'(count) * 40'(est_scale);
    angle = product[16 +: PHASE_BITS];

    elapsed_sum = (ELAPSED_W + 1)'(est_elapsed) + (ELAPSED_W + 1)'(est_tick);
    if (elapsed_sum > (ELAPSED_W + 1)'(ELAPSED_MAX)) begin
      est_elapsed = ELAPSED_MAX;
    end else begin
      est_elapsed = elapsed_sum[ELAPSED_W-1:0];
    end

    // Shortest way round the circle between reference and new phase.
    phase_dist = angle - est_ref_angle;
    if (phase_dist > (PHASE_BITS)'(1 << (PHASE_BITS - 1))) begin
      phase_dist = '0 - phase_dist;
    end

    est.updated = 1'b0;
    if (phase_dist > PHASE_BITS'(est_thresh) || est_elapsed > ELAPSED_W'(est_timeout)) begin
      if (phase_dist == '0) begin
        mag = '0;
      end else if (est_elapsed == '0) begin
        mag = '1;
      end else begin
        mag = (64'(phase_dist) * 64'(US_PER_SECOND)) / 64'(est_elapsed);
      end
      if (est_dir) begin
        if (mag > 64'h7FFF_FFFF) begin
          mag = 64'h7FFF_FFFF;
        end
        est_speed = mag[31:0];
      end else begin
        if (mag > 64'h8000_0000) begin
          mag = 64'h8000_0000;
        end
        est_speed = 32'd0 - mag[31:0];
      end
      est_ref_angle = angle;
      est_elapsed = '0;
      est.updated = 1'b1;
    end

    est.angle = ANGLE_PORT_W'(angle);
    est.speed = est_speed;
    return est;
  endfunction

  // Driver: offers queued samples and records the estimate of each transfer.
  always @(posedge clk) begin : drive_samples
    encoder_sample_t next_sample;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_estimates.push_back(estimate_tick(in_position_count, in_direction_flag));
      end
      if (!in_valid || !in_stall) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_sample = pending_samples.pop_front();
          in_valid <= 1'b1;
          in_position_count <= next_sample.count;
          in_direction_flag <= next_sample.dir;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every result transfer against the oldest estimate.
  always @(posedge clk) begin : check_estimates
    angle_speed_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_estimates.size() == 0) begin
          $display("%0t: unexpected result, angle %0d speed %0d updated %0b", $time,
                   out_elec_angle, out_speed, out_speed_updated);
          mismatch_count++;
        end else begin
          want = expected_estimates.pop_front();
          if (out_elec_angle !== want.angle) begin
            $display("%0t: elec_angle expected %0d actual %0d", $time, want.angle,
                     out_elec_angle);
            mismatch_count++;
          end
          if (out_speed !== want.speed) begin
            $display("%0t: speed expected %0d actual %0d", $time, want.speed, out_speed);
            mismatch_count++;
          end
          if (out_speed_updated !== want.updated) begin
            $display("%0t: speed_updated expected %0b actual %0b", $time, want.updated,
                     out_speed_updated);
            mismatch_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic push_sample(logic [COUNT_PORT_W-1:0] count, logic dir);
    encoder_sample_t s;
    s.count = count;
    s.dir = dir;
    pending_samples.push_back(s);
  endtask

  // Mostly smooth motion with random steps, mixed with stops at zero and jumps.
  task automatic push_motion(int n, int step_max);
    int r;
    int delta;
    logic fwd;
    logic flip;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 8) begin
        walk_count = '0;
        push_sample(walk_count, 1'($urandom_range(1)));
      end else if (r < 15) begin
        walk_count = COUNT_PORT_W'($urandom);
        push_sample(walk_count, 1'($urandom_range(1)));
      end else begin
        delta = $urandom_range(step_max);
        fwd = 1'($urandom_range(1));
        flip = ($urandom_range(9) == 0);
        if (fwd) begin
          walk_count = walk_count + COUNT_PORT_W'(delta);
        end else begin
          walk_count = walk_count - COUNT_PORT_W'(delta);
        end
        push_sample(walk_count, fwd ^ flip);
      end
    end
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_ELEC_SCALE:      est_scale = data[SCALE_W-1:0];
      REG_ANGLE_THRESHOLD: est_thresh = data[THRESH_W-1:0];
      REG_TIMEOUT_US:      est_timeout = data[TIMEOUT_W-1:0];
      REG_TICK_US:         est_tick = data[TICK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] scale, logic [CFG_DATA_W-1:0] thresh,
                           logic [CFG_DATA_W-1:0] timeout, logic [CFG_DATA_W-1:0] tick);
    write_reg(REG_ELEC_SCALE, scale);
    write_reg(REG_ANGLE_THRESHOLD, thresh);
    write_reg(REG_TIMEOUT_US, timeout);
    write_reg(REG_TICK_US, tick);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    @(posedge clk);
    send_idle_pct <= send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  // Waits until every sample has been taken and every estimate has arrived.
  task automatic wait_idle();
    do begin
      @(posedge clk);
    end while (pending_samples.size() != 0 || in_valid || expected_estimates.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Stimulus sequence, one phase per register setting.
  initial begin : stimulus
    logic [CFG_DATA_W-1:0] junk;
    int step_max;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: extremes of the count, the half turn, direction latch
    // after a zero count and wrap across zero.
    set_idling(0, 0);
    push_sample(16'h0000, 1'b0);
    push_sample(16'hFFFF, 1'b1);
    push_sample(16'h0800, 1'b1);
    push_sample(16'h0801, 1'b1);
    push_sample(16'h0000, 1'b0);
    push_sample(16'h0001, 1'b1);
    push_sample(16'hFFFF, 1'b0);
    push_sample(16'h0C00, 1'b1);
    push_sample(16'h4000, 1'b1);
    push_sample(16'hAAAA, 1'b0);
    push_sample(16'h5555, 1'b1);
    push_motion(100, 40);
    wait_idle();

    // Largest scale, every tick times out; a standing count gives zero speed.
    configure(24'hFFFFFF, 24'd0, 24'd0, 24'd1000);
    set_idling(49, 0);
    push_sample(16'd100, 1'b1);
    push_sample(16'd100, 1'b1);
    push_sample(16'd101, 1'b1);
    push_sample(16'd99, 1'b0);
    push_sample(16'hFFFF, 1'b1);
    push_motion(100, 3);
    wait_idle();

    // Zero tick period: any movement saturates the speed in either direction.
    configure(24'h010000, 24'd0, 24'd65535, 24'd0);
    set_idling(0, 49);
    push_sample(16'd1, 1'b1);
    push_sample(16'd1, 1'b1);
    push_sample(16'd3000, 1'b1);
    push_sample(16'd3000, 1'b1);
    push_sample(16'd100, 1'b0);
    push_motion(100, 200);
    wait_idle();

    // Zero scale with the largest threshold, timeout and tick.
    configure(24'd0, 24'd32767, 24'd65535, 24'd1023);
    set_idling(26, 26);
    push_motion(100, 600);
    wait_idle();

    // Shortest tick so that large steps saturate.
    configure(24'($urandom_range(24'h004000, 24'h200000)), 24'd0, 24'd65535, 24'd1);
    set_idling(0, 0);
    push_motion(100, 20);
    wait_idle();

    // Random settings, with junk above each register's width.
    for (int p = 0; p < 5; p++) begin
      junk = CFG_DATA_W'($urandom);
      configure(($urandom_range(2) == 0) ? CFG_DATA_W'($urandom)
                                         : 24'($urandom_range(24'h004000, 24'h200000)),
                {junk[CFG_DATA_W-1:THRESH_W],
                 THRESH_W'(($urandom_range(1) == 0) ? $urandom_range(2000)
                                                     : $urandom_range(32767))},
                {junk[CFG_DATA_W-1:TIMEOUT_W], TIMEOUT_W'($urandom_range(65535))},
                {junk[CFG_DATA_W-1:TICK_W], TICK_W'($urandom_range(1, 1000))});
      case (p % 4)
        0: set_idling(49, 0);
        1: set_idling(0, 49);
        2: set_idling(26, 26);
        default: set_idling(0, 0);
      endcase
      case ($urandom_range(3))
        0: step_max = 3;
        1: step_max = 40;
        2: step_max = 300;
        default: step_max = 4000;
      endcase
      push_motion(105, step_max);
      wait_idle();
    end

    if (mismatch_count == 0 && expected_estimates.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/enc_ase_pkg.sv
hw/rtl/encoder_angle_speed_estimator_top.sv
sim/tb_encoder_angle_speed_estimator_top.sv
